FILE: hdl/spkd_pkg.sv
// ----------------------------------------------------------------------------
// spkd_pkg
// types and constants shared by the spike packet key decoder
// ----------------------------------------------------------------------------
package spkd_pkg;

    localparam int unsigned POS_MAX    = 2047;
    localparam int unsigned MIN_LENGTH = 9;
    localparam int unsigned KEY_START  = 6;

    typedef enum logic [2:0] {
        K_SPIKE     = 3'd0,
        K_MISSING   = 3'd1,
        K_OK        = 3'd2,
        K_COMMAND   = 3'd3,
        K_SHORT     = 3'd4,
        K_TRUNCATED = 3'd5
    } t_kind;

    typedef struct packed {
        logic        func;
        logic [7:0]  byte_value;
        logic        last_byte;
        logic [7:0]  entry_index;
        logic [31:0] entry_key;
        logic [30:0] entry_neuron;
        logic        entry_valid;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] spike_time;
        logic [30:0] neuron;
        logic [31:0] routing_key;
        logic        final_result;
    } t_out;

    // search token handed from cell to cell
    typedef struct packed {
        logic        active;
        logic        found;
        logic [31:0] key;
        logic [30:0] neuron;
    } t_probe;

endpackage

FILE: hdl/spike_packet_key_decoder.sv
// ----------------------------------------------------------------------------
// spike_packet_key_decoder
// byte-wide spike packet parser with a key-to-neuron lookup chain
// ----------------------------------------------------------------------------
// One beat is taken at a time. A table write or a byte that completes no key
// leaves the control in S_IDLE; a final byte that completes no key goes on to
// S_STATUS, which loads its status into the output register. A byte that
// completes a counted key sends a probe down the chain of TABLE_ENTRIES slot
// cells, one cell a cycle; S_SEARCH then captures the probe and S_SPIKE loads
// the result, and only then is the next beat taken, after S_STATUS as well
// when that byte also ends the packet. While a result waits in the output
// register with i_ready low, no beat is taken. Status and spike results
// leave through that one output register, one result a beat, the last one
// flagged with final_result.
module spike_packet_key_decoder #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  spkd_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output spkd_pkg::t_out  o_data
);
    import spkd_pkg::*;

    // control states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SPIKE  = 4'b0100,
        S_STATUS = 4'b1000
    } t_state;

    t_state      r_state;
    logic [10:0] r_pos;
    logic [7:0]  r_total;
    logic        r_hdr;
    logic [31:0] r_time;
    logic [23:0] r_part;
    logic [7:0]  r_done;
    logic        r_last;     // status owed after the spike
    logic [2:0]  r_skind;    // status kind owed
    logic        r_ovalid;
    t_out        r_out;
    t_probe      r_hit;      // probe caught at the end of the chain

    t_probe chain [TABLE_ENTRIES+1];
    logic   wr_sel [TABLE_ENTRIES];

    logic   take;
    logic   out_free;
    logic   out_load;
    logic [10:0] len;
    logic [1:0]  off;
    logic        keyhit;
    logic [2:0]  kind_now;
    logic [7:0]  done_now;

    assign out_free = !r_ovalid || i_ready;
    assign out_load = out_free && (r_state == S_SPIKE || r_state == S_STATUS);
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign take     = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign o_data   = r_out;

    assign off    = 2'(r_pos - 11'(KEY_START));
    assign keyhit = !i_data.func && r_pos >= 11'(KEY_START) && off == 2'd3
                    && r_hdr && r_done < r_total;
    assign len    = r_pos + 11'd1;
    assign done_now = keyhit ? r_done + 8'd1 : r_done;

    always_comb begin
        if (r_pos < 11'(MIN_LENGTH - 1))  kind_now = K_SHORT;
        else if (!r_hdr)                  kind_now = K_COMMAND;
        else if (done_now < r_total)      kind_now = K_TRUNCATED;
        else                              kind_now = K_OK;
    end

    // probe enters the chain here
    always_comb begin
        chain[0].active = take && keyhit;
        chain[0].found  = 1'b0;
        chain[0].key    = {i_data.byte_value, r_part};
        chain[0].neuron = '0;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            assign wr_sel[g] = take && i_data.func
                               && {24'd0, i_data.entry_index} == 32'(g);
            spkd_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_wr     (wr_sel[g]),
                .i_key    (i_data.entry_key),
                .i_neuron (i_data.entry_neuron),
                .i_valid  (i_data.entry_valid),
                .i_probe  (chain[g]),
                .o_probe  (chain[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_total  <= '0;
            r_hdr    <= 1'b0;
            r_time   <= '0;
            r_part   <= '0;
            r_done   <= '0;
            r_last   <= 1'b0;
            r_skind  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // output register fills on a load, empties when the beat is taken
            r_ovalid <= out_load || (r_ovalid && !i_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (take && !i_data.func) begin
                        if (r_pos == 11'd0) r_total <= i_data.byte_value;
                        else if (r_pos == 11'd1)
                            r_hdr <= (i_data.byte_value & 8'hFC) == 8'h38;
                        else if (r_pos < 11'(KEY_START))
                            r_time <= r_time | (32'(i_data.byte_value)
                                      << {r_pos[1:0] - 2'd2, 3'b000});
                        else if (off == 2'd0) r_part <= {16'd0, i_data.byte_value};
                        else if (off == 2'd1) r_part[15:8]  <= i_data.byte_value;
                        else if (off == 2'd2) r_part[23:16] <= i_data.byte_value;
                        if (r_pos < 11'(POS_MAX)) r_pos <= len;
                        r_done  <= done_now;
                        r_last  <= i_data.last_byte;
                        r_skind <= kind_now;
                        if (keyhit) begin
                            r_state <= S_SEARCH;
                        end else if (i_data.last_byte) begin
                            r_state <= S_STATUS;
                        end
                    end
                end
                S_SEARCH: begin
                    // the probe sits at the chain end for one cycle only
                    if (chain[TABLE_ENTRIES].active) begin
                        r_hit   <= chain[TABLE_ENTRIES];
                        r_state <= S_SPIKE;
                    end
                end
                S_SPIKE: begin
                    if (out_free) begin
                        r_out.kind         <= r_hit.found ? K_SPIKE : K_MISSING;
                        r_out.spike_time   <= r_hit.found ? r_time : '0;
                        r_out.neuron       <= r_hit.found ? r_hit.neuron : '0;
                        r_out.routing_key  <= r_hit.key;
                        r_out.final_result <= !r_last;
                        r_state <= r_last ? S_STATUS : S_IDLE;
                    end
                end
                S_STATUS: begin
                    if (out_free) begin
                        r_out.kind         <= r_skind;
                        r_out.spike_time   <= '0;
                        r_out.neuron       <= '0;
                        r_out.routing_key  <= '0;
                        r_out.final_result <= 1'b1;
                        r_pos   <= '0;
                        r_total <= '0;
                        r_hdr   <= 1'b0;
                        r_time  <= '0;
                        r_part  <= '0;
                        r_done  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_probe_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[TABLE_ENTRIES].active |-> r_state == S_SEARCH)
        else $error("probe left chain outside search");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("ready while busy");
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind >= K_OK) |-> o_data.final_result)
        else $error("status not final");
`endif

endmodule

FILE: hdl/spkd_cell.sv
// ----------------------------------------------------------------------------
// spkd_cell
// one table slot: holds key, neuron and valid bit, matches a passing probe
// ----------------------------------------------------------------------------
module spkd_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  logic [31:0]     i_key,
    input  logic [30:0]     i_neuron,
    input  logic            i_valid,
    input  spkd_pkg::t_probe i_probe,
    output spkd_pkg::t_probe o_probe
);
    import spkd_pkg::*;

    logic        r_valid;
    logic [31:0] r_key;
    logic [30:0] r_neuron;
    t_probe      r_probe;
    t_probe      n_probe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= i_valid;
        end
        if (i_wr) begin
            r_key    <= i_key;
            r_neuron <= i_neuron;
        end
    end

    always_comb begin
        n_probe = i_probe;
        if (i_probe.active && !i_probe.found && r_valid && r_key == i_probe.key) begin
            n_probe.found  = 1'b1;
            n_probe.neuron = r_neuron;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.active <= 1'b0;
        end else begin
            r_probe.active <= n_probe.active;
        end
        r_probe.found  <= n_probe.found;
        r_probe.key    <= n_probe.key;
        r_probe.neuron <= n_probe.neuron;
    end

    assign o_probe = r_probe;

endmodule

FILE: bench/tb_spike_packet_key_decoder.sv
// ----------------------------------------------------------------------------
// tb_spike_packet_key_decoder
// self-checking bench for the byte-wide spike packet key decoder
// ----------------------------------------------------------------------------
// Beats go in through a valid/ready sender; every accepted beat is run through
// a local copy of the parser and its key table, and the results it produces
// are queued. A checker process pops one expectation per output beat and
// compares it field by field. Directed packets come first, then random
// traffic in four idling phases.
// ----------------------------------------------------------------------------
module tb_spike_packet_key_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import spkd_pkg::*;

    localparam int SLOTS       = 256;
    localparam int CYCLE_LIMIT = 3000000;
    // a counted key walks the whole slot chain before it leaves
    localparam int DRAIN       = 4 * SLOTS + 64;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    spike_packet_key_decoder #(.TABLE_ENTRIES(SLOTS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // parser state mirrored in the bench
    logic [10:0] pkt_pos;
    logic [7:0]  pkt_key_total;
    logic        pkt_is_data;
    logic [31:0] pkt_stamp;
    logic [23:0] pkt_partial;
    logic [7:0]  pkt_keys_done;
    logic [31:0] slot_key    [SLOTS];
    logic [30:0] slot_neuron [SLOTS];
    logic        slot_live   [SLOTS];

    t_out decoded_q[$];

    int cycle_count;
    int mismatch_count;
    int beats_sent;
    int results_seen;
    int spikes_seen;
    int missing_seen;
    int status_seen;
    int send_idle_pct;
    int recv_stall_pct;

    // clock and watchdog
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("spike_packet_key_decoder: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction: one accepted beat in, zero to two results queued
    // ------------------------------------------------------------------------
    function automatic t_out make_result(t_kind k, logic [31:0] tm, logic [30:0] nrn,
                                         logic [31:0] key);
        t_out r;
        r.kind         = k;
        r.spike_time   = tm;
        r.neuron       = nrn;
        r.routing_key  = key;
        r.final_result = 1'b0;
        return r;
    endfunction

    function automatic void decode_beat(t_in x);
        t_out        res[$];
        int          off;
        int          length;
        logic [31:0] key;
        logic        hit;
        logic [30:0] nrn;
        t_kind       status;
        if (x.func) begin
            // slot writes never produce a result and leave the packet alone
            slot_key[x.entry_index]    = x.entry_key;
            slot_neuron[x.entry_index] = x.entry_neuron;
            slot_live[x.entry_index]   = x.entry_valid;
            return;
        end
        if (pkt_pos == 0) begin
            pkt_key_total = x.byte_value;
        end else if (pkt_pos == 1) begin
            pkt_is_data = ((x.byte_value & 8'hFC) == 8'h38);
        end else if (pkt_pos < KEY_START) begin
            pkt_stamp = pkt_stamp | (32'(x.byte_value) << ((pkt_pos - 2) * 8));
        end else begin
            off = (pkt_pos - KEY_START) & 3;
            if (off < 3) begin
                if (off == 0)
                    pkt_partial = '0;
                pkt_partial = pkt_partial | (24'(x.byte_value) << (off * 8));
            end else if (pkt_is_data && pkt_keys_done < pkt_key_total) begin
                key = {x.byte_value, pkt_partial};
                hit = 1'b0;
                nrn = '0;
                // lowest live slot with a matching key wins
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && slot_live[i] && slot_key[i] == key) begin
                        hit = 1'b1;
                        nrn = slot_neuron[i];
                    end
                end
                if (hit)
                    res = {res, make_result(K_SPIKE, pkt_stamp, nrn, key)};
                else
                    res = {res, make_result(K_MISSING, '0, '0, key)};
                pkt_keys_done++;
            end
        end
        length = int'(pkt_pos) + 1;
        if (pkt_pos < POS_MAX)
            pkt_pos++;
        if (x.last_byte) begin
            if (length < MIN_LENGTH)
                status = K_SHORT;
            else if (!pkt_is_data)
                status = K_COMMAND;
            else if (pkt_keys_done < pkt_key_total)
                status = K_TRUNCATED;
            else
                status = K_OK;
            res = {res, make_result(status, '0, '0, '0)};
            pkt_pos       = '0;
            pkt_key_total = '0;
            pkt_is_data   = 1'b0;
            pkt_stamp     = '0;
            pkt_partial   = '0;
            pkt_keys_done = '0;
        end
        if (res.size() > 0)
            res[res.size() - 1].final_result = 1'b1;
        decoded_q = {decoded_q, res};
    endfunction

    // ------------------------------------------------------------------------
    // sender: drive one beat, hold until taken, then maybe go idle
    // ------------------------------------------------------------------------
    task automatic send_beat(t_in x);
        int gap;
        i_valid <= 1'b1;
        i_data  <= x;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        decode_beat(x);
        beats_sent++;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // unused fields carry random junk so that every bit moves
    function automatic t_in junk_beat();
        t_in x;
        x.func         = 1'b0;
        x.byte_value   = 8'($urandom);
        x.last_byte    = 1'($urandom);
        x.entry_index  = 8'($urandom);
        x.entry_key    = $urandom;
        x.entry_neuron = 31'($urandom);
        x.entry_valid  = 1'($urandom);
        return x;
    endfunction

    task automatic write_slot(int idx, logic [31:0] key, logic [30:0] nrn, logic live);
        t_in x;
        x              = junk_beat();
        x.func         = 1'b1;
        x.entry_index  = 8'(idx);
        x.entry_key    = key;
        x.entry_neuron = nrn;
        x.entry_valid  = live;
        send_beat(x);
    endtask

    // sends a byte string as one packet; slot writes may slip in between bytes
    task automatic send_packet(logic [7:0] bytes[$], int write_pct);
        t_in x;
        foreach (bytes[i]) begin
            if ($urandom_range(99) < write_pct)
                write_slot($urandom_range(SLOTS - 1), $urandom, 31'($urandom), 1'($urandom));
            x            = junk_beat();
            x.byte_value = bytes[i];
            x.last_byte  = (i == bytes.size() - 1);
            send_beat(x);
        end
    endtask

    function automatic void push_word(ref logic [7:0] bytes[$], input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            bytes = {bytes, w[8*i +: 8]};
    endfunction

    // a key that sits in a live slot most of the time, otherwise anything
    function automatic logic [31:0] pick_key();
        int idx;
        idx = $urandom_range(SLOTS - 1);
        if ($urandom_range(99) < 75 && slot_live[idx])
            return slot_key[idx];
        return $urandom;
    endfunction

    function automatic logic [7:0] command_header();
        logic [7:0] h;
        h = 8'($urandom);
        while ((h & 8'hFC) == 8'h38)
            h = 8'($urandom);
        return h;
    endfunction

    // ------------------------------------------------------------------------
    // checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            case (t_kind'(o_data.kind))
                K_SPIKE:   spikes_seen++;
                K_MISSING: missing_seen++;
                default:   status_seen++;
            endcase
            if (decoded_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: %p", o_data);
            end else begin
                want = decoded_q.pop_front();
                if (o_data.kind !== want.kind || o_data.spike_time !== want.spike_time ||
                    o_data.neuron !== want.neuron ||
                    o_data.routing_key !== want.routing_key ||
                    o_data.final_result !== want.final_result) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result beat %0d: expected %p, got %p",
                                 results_seen, want, o_data);
                end
            end
        end
        if (i_rst_n)
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        logic [7:0] p[$];
        // extremes of the table fields, a duplicated key and a removed slot
        write_slot(0, 32'h0000_0000, 31'h7FFF_FFFF, 1'b1);
        write_slot(SLOTS - 1, 32'hFFFF_FFFF, 31'h0, 1'b1);
        write_slot(5, 32'h1234_5678, 31'h55, 1'b1);
        write_slot(3, 32'h1234_5678, 31'h33, 1'b1);
        write_slot(7, 32'hCAFE_F00D, 31'h77, 1'b0);

        // one-byte packet: too short
        p = '{8'hFF};
        send_packet(p, 0);

        // command header with a key that must not be looked up
        p = '{8'h01, 8'h00};
        push_word(p, 32'hFFFF_FFFF);
        push_word(p, 32'h0000_0000);
        send_packet(p, 0);

        // data packet with two counted keys; the extra key that the last byte completes is ignored
        p = '{8'h02, 8'h3B};
        push_word(p, 32'hDEAD_BEEF);
        push_word(p, 32'h0000_0000);
        push_word(p, 32'hFFFF_FFFF);
        push_word(p, 32'hCAFE_F00D);
        send_packet(p, 0);

        // truncated: duplicate key finds the lower slot, removed key is missing
        p = '{8'h03, 8'h38};
        push_word(p, 32'h0000_0001);
        push_word(p, 32'h1234_5678);
        push_word(p, 32'hCAFE_F00D);
        p = {p, 8'hAA};
        send_packet(p, 0);
    endtask

    task automatic test_random_traffic(int n_beats);
        logic [7:0] p[$];
        int         stop_at;
        int         count;
        int         sel;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            sel = $urandom_range(99);
            p.delete();
            if (sel < 15) begin
                // refresh the table, sometimes reusing a key to make duplicates
                write_slot($urandom_range(SLOTS - 1), pick_key(), 31'($urandom),
                           $urandom_range(99) < 85);
            end else if (sel < 70) begin
                // well-formed data packet, at times one key more than counted
                count = $urandom_range(0, 4);
                p = {p, 8'(count)};
                p = {p, 8'h38 | 8'($urandom_range(3))};
                push_word(p, $urandom);
                for (int k = 0; k < count + ($urandom_range(9) == 0); k++)
                    push_word(p, pick_key());
                send_packet(p, 5);
            end else if (sel < 80) begin
                // data packet cut short somewhere
                count = $urandom_range(1, 4);
                p = {p, 8'(count)};
                p = {p, 8'h38 | 8'($urandom_range(3))};
                push_word(p, $urandom);
                for (int k = 0; k < count; k++)
                    push_word(p, pick_key());
                repeat ($urandom_range(1, p.size() - 1))
                    void'(p.pop_back());
                send_packet(p, 5);
            end else if (sel < 88) begin
                p = {p, 8'($urandom)};
                p = {p, command_header()};
                repeat ($urandom_range(0, 14))
                    p = {p, 8'($urandom)};
                send_packet(p, 5);
            end else begin
                // noise: random bytes of random length
                repeat ($urandom_range(1, 16))
                    p = {p, 8'($urandom)};
                send_packet(p, 5);
            end
        end
    endtask

    initial begin
        cycle_count    = 0;
        mismatch_count = 0;
        beats_sent     = 0;
        results_seen   = 0;
        spikes_seen    = 0;
        missing_seen   = 0;
        status_seen    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pkt_pos        = '0;
        pkt_key_total  = '0;
        pkt_is_data    = 1'b0;
        pkt_stamp      = '0;
        pkt_partial    = '0;
        pkt_keys_done  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_key[i]    = '0;
            slot_neuron[i] = '0;
            slot_live[i]   = 1'b0;
        end
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(420);
        send_idle_pct  = 78;
        test_random_traffic(420);
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        test_random_traffic(420);
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        test_random_traffic(420);
        i_valid <= 1'b0;

        while (decoded_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("covered %0d beats: %0d spikes, %0d missing keys, %0d packet statuses",
                 beats_sent, spikes_seen, missing_seen, status_seen);
        $display("idling phases: none, sender gaps, receiver stalls, both");
        if (mismatch_count == 0 && decoded_q.size() == 0) begin
            $display("spike_packet_key_decoder: match");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatch_count,
                     decoded_q.size());
            $display("spike_packet_key_decoder: mismatch");
        end
        $finish;
    end

endmodule
